/* sv/cec_pkg.sv */
// Shared types, constants and calendar helpers for the calendar epoch converter.
`default_nettype none

package cec_pkg;

  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [11:0] LAST_YEAR     = 12'd2099;
  localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [2:0]  WD_EPOCH      = 3'd3;

  // reciprocals of 675, 225 and 15, applied after shifting out 2^7, 2^4 and 2^2
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP    = 14'd9321;
  localparam logic [10:0] MIN_RECIP     = 11'd1093;

  typedef logic [4:0] op_t;
  localparam op_t OP_NONE  = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_BAD   = 5'd2;
  localparam op_t OP_EYEAR = 5'd3;
  localparam op_t OP_EMON  = 5'd4;
  localparam op_t OP_EDAY  = 5'd5;
  localparam op_t OP_EMUL  = 5'd6;
  localparam op_t OP_EADD  = 5'd7;
  localparam op_t OP_DLOAD = 5'd8;
  localparam op_t OP_DREM  = 5'd9;
  localparam op_t OP_HLOAD = 5'd10;
  localparam op_t OP_MLOAD = 5'd11;
  localparam op_t OP_SLOAD = 5'd12;
  localparam op_t OP_DYEAR = 5'd13;
  localparam op_t OP_DOY   = 5'd14;
  localparam op_t OP_DMON  = 5'd15;
  localparam op_t OP_DDAY  = 5'd16;
  localparam op_t OP_OUT   = 5'd17;
  localparam op_t OP_HREM  = 5'd18;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [31:0] in_epoch_seconds;
  } cec_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_epoch_seconds;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday_monday_based;
    logic [2:0]  weekday_sunday_based;
  } cec_out_t;

  typedef struct packed {
    op_t op;
  } cec_cmd_t;

  typedef struct packed {
    logic is_decode;
    logic enc_valid;
    logic dec_valid;
    logic enc_year_done;
    logic enc_mon_done;
    logic dec_year_done;
    logic dec_mon_done;
    logic out_free;
  } cec_stat_t;

  function automatic logic cec_leap(input logic [11:0] year);
    return (year[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] cec_mlen(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] cec_wd_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= 4'd7) begin
      sum = sum - 4'd7;
    end
    return sum[2:0];
  endfunction

  function automatic logic [2:0] cec_mod7(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd28) begin
      r = r - 5'd28;
    end else if (r >= 5'd21) begin
      r = r - 5'd21;
    end else if (r >= 5'd14) begin
      r = r - 5'd14;
    end else if (r >= 5'd7) begin
      r = r - 5'd7;
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

/* sv/cec_in_if.sv */
// Request channel interface: valid/ready handshake with date and seconds payload.
`default_nettype none

interface cec_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic [31:0] in_epoch_seconds;

  modport source (
    output valid, command, in_year, in_month, in_day, in_hour, in_minute, in_second,
           in_epoch_seconds,
    input  ready
  );

  modport sink (
    input  valid, command, in_year, in_month, in_day, in_hour, in_minute, in_second,
           in_epoch_seconds,
    output ready
  );
endinterface

`default_nettype wire

/* sv/cec_out_if.sv */
// Result channel interface: valid/ready handshake with calendar result payload.
`default_nettype none

interface cec_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] out_epoch_seconds;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [8:0]  day_of_year;
  logic [2:0]  weekday_monday_based;
  logic [2:0]  weekday_sunday_based;

  modport source (
    output valid, ok, out_epoch_seconds, out_year, out_month, out_day, out_hour,
           out_minute, out_second, day_of_year, weekday_monday_based,
           weekday_sunday_based,
    input  ready
  );

  modport sink (
    input  valid, ok, out_epoch_seconds, out_year, out_month, out_day, out_hour,
           out_minute, out_second, day_of_year, weekday_monday_based,
           weekday_sunday_based,
    output ready
  );
endinterface

`default_nettype wire

/* sv/calendar_epoch_converter.sv */
// Top level of the calendar epoch converter: sequencer, datapath and channel wiring.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      command, date and time fields, epoch seconds
//   out_ch    out   valid / ready      ok, epoch seconds, calendar fields, weekdays
//
// Encode time is set by the year and month walk. Decode first runs five multiply and
// remainder steps, then the same walk.
// One transaction is in work at a time.
// A finished result waits in the output register while the next transaction is taken.
// Reset is synchronous, active low, and clears the sequencer and the result valid.
`default_nettype none

module calendar_epoch_converter
  import cec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  cec_in_if.sink    in_ch,
  cec_out_if.source out_ch
);

  cec_cmd_t  cmd;
  cec_stat_t stat;
  cec_in_t   in_data;
  cec_out_t  out_data;
  logic      in_ready;
  logic      out_valid;

  assign in_data.command          = in_ch.command;
  assign in_data.in_year          = in_ch.in_year;
  assign in_data.in_month         = in_ch.in_month;
  assign in_data.in_day           = in_ch.in_day;
  assign in_data.in_hour          = in_ch.in_hour;
  assign in_data.in_minute        = in_ch.in_minute;
  assign in_data.in_second        = in_ch.in_second;
  assign in_data.in_epoch_seconds = in_ch.in_epoch_seconds;
  assign in_ch.ready              = in_ready;

  cec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cec_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_ch.valid                = out_valid;
  assign out_ch.ok                   = out_data.ok;
  assign out_ch.out_epoch_seconds    = out_data.out_epoch_seconds;
  assign out_ch.out_year             = out_data.out_year;
  assign out_ch.out_month            = out_data.out_month;
  assign out_ch.out_day              = out_data.out_day;
  assign out_ch.out_hour             = out_data.out_hour;
  assign out_ch.out_minute           = out_data.out_minute;
  assign out_ch.out_second           = out_data.out_second;
  assign out_ch.day_of_year          = out_data.day_of_year;
  assign out_ch.weekday_monday_based = out_data.weekday_monday_based;
  assign out_ch.weekday_sunday_based = out_data.weekday_sunday_based;

endmodule

`default_nettype wire

/* sv/cec_ctrl.sv */
// Sequencer for the calendar epoch converter: issues datapath operations per step.
`default_nettype none

module cec_ctrl
  import cec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cec_stat_t stat,
  output cec_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_EYEAR = 4'd2;
  localparam logic [3:0] S_EMON  = 4'd3;
  localparam logic [3:0] S_EDAY  = 4'd4;
  localparam logic [3:0] S_EMUL  = 4'd5;
  localparam logic [3:0] S_EADD  = 4'd6;
  localparam logic [3:0] S_DREM  = 4'd7;
  localparam logic [3:0] S_DHOUR = 4'd8;
  localparam logic [3:0] S_DHREM = 4'd9;
  localparam logic [3:0] S_DMIN  = 4'd10;
  localparam logic [3:0] S_DSEC  = 4'd11;
  localparam logic [3:0] S_DYEAR = 4'd12;
  localparam logic [3:0] S_DMON  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_decode) begin
          if (stat.dec_valid) begin
            cmd.op    = OP_DLOAD;
            state_nxt = S_DREM;
          end else begin
            cmd.op    = OP_BAD;
            state_nxt = S_DONE;
          end
        end else begin
          if (stat.enc_valid) begin
            state_nxt = S_EYEAR;
          end else begin
            cmd.op    = OP_BAD;
            state_nxt = S_DONE;
          end
        end
      end
      S_EYEAR: begin
        if (stat.enc_year_done) begin
          state_nxt = S_EMON;
        end else begin
          cmd.op = OP_EYEAR;
        end
      end
      S_EMON: begin
        if (stat.enc_mon_done) begin
          state_nxt = S_EDAY;
        end else begin
          cmd.op = OP_EMON;
        end
      end
      S_EDAY: begin
        cmd.op    = OP_EDAY;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        cmd.op    = OP_EMUL;
        state_nxt = S_EADD;
      end
      S_EADD: begin
        cmd.op    = OP_EADD;
        state_nxt = S_DONE;
      end
      S_DREM: begin
        cmd.op    = OP_DREM;
        state_nxt = S_DHOUR;
      end
      S_DHOUR: begin
        cmd.op    = OP_HLOAD;
        state_nxt = S_DHREM;
      end
      S_DHREM: begin
        cmd.op    = OP_HREM;
        state_nxt = S_DMIN;
      end
      S_DMIN: begin
        cmd.op    = OP_MLOAD;
        state_nxt = S_DSEC;
      end
      S_DSEC: begin
        cmd.op    = OP_SLOAD;
        state_nxt = S_DYEAR;
      end
      S_DYEAR: begin
        if (stat.dec_year_done) begin
          cmd.op    = OP_DOY;
          state_nxt = S_DMON;
        end else begin
          cmd.op = OP_DYEAR;
        end
      end
      S_DMON: begin
        if (stat.dec_mon_done) begin
          cmd.op    = OP_DDAY;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_DMON;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> in_ready)
    else $error("transaction loaded while the input is not ready");

  a_out_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> stat.out_free)
    else $error("result issued while the output register is occupied");

  a_load_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |=> (state_r == S_CHECK))
    else $error("accepted transaction not followed by the check step");

endmodule

`default_nettype wire

/* sv/cec_dp.sv */
// Datapath: input hold, calendar walk, reciprocal dividers and result register.
`default_nettype none

module cec_dp
  import cec_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cec_cmd_t cmd,
  input  wire cec_in_t  in_data,
  output cec_stat_t     stat,
  input  wire logic     out_ready,
  output logic          out_valid,
  output cec_out_t      out_data
);

  logic        dec_r, dec_nxt;
  logic        ok_r, ok_nxt;
  logic [11:0] y_r, y_nxt;
  logic [3:0]  mo_r, mo_nxt;
  logic [4:0]  d_r, d_nxt;
  logic [4:0]  h_r, h_nxt;
  logic [5:0]  mi_r, mi_nxt;
  logic [5:0]  s_r, s_nxt;
  logic [31:0] secs_r, secs_nxt;
  logic [11:0] cy_r, cy_nxt;
  logic [3:0]  cm_r, cm_nxt;
  logic [15:0] days_r, days_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [16:0] part_r, part_nxt;
  logic        out_valid_r, out_valid_nxt;
  cec_out_t    out_r, out_nxt;

  logic        cy_leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [4:0]  in_mlen;
  logic [32:0] day_secs;
  logic [16:0] hour_secs;
  logic [11:0] min_secs;
  logic [4:0]  d_m1;
  logic [50:0] day_prod;
  logic [25:0] hour_prod;
  logic [19:0] min_prod;

  assign cy_leap   = cec_leap(cy_r);
  assign ylen      = 9'd365 + {8'b0, cy_leap};
  assign mlen      = cec_mlen(cy_leap, cm_r);
  assign in_mlen   = cec_mlen(cec_leap(y_r), mo_r);
  assign d_m1      = d_r - 5'd1;
  assign day_secs  = {1'b0, days_r} * {16'b0, SECS_PER_DAY};
  assign hour_secs = {12'b0, h_r} * SECS_PER_HOUR;
  assign min_secs  = {6'b0, mi_r} * SECS_PER_MIN[11:0];
  assign day_prod  = {26'b0, secs_r[31:7]} * {25'b0, DAY_RECIP};
  assign hour_prod = {13'b0, part_r[16:4]} * {12'b0, HOUR_RECIP};
  assign min_prod  = {10'b0, part_r[11:2]} * {9'b0, MIN_RECIP};

  always_comb begin
    stat.is_decode     = (dec_r == CMD_DECODE);
    stat.enc_valid     = (y_r >= EPOCH_YEAR) && (y_r <= LAST_YEAR) &&
                         (mo_r >= 4'd1) && (mo_r <= 4'd12) &&
                         (d_r >= 5'd1) && (d_r <= in_mlen) &&
                         (h_r <= 5'd23) && (mi_r <= 6'd59) && (s_r <= 6'd59);
    stat.dec_valid     = (secs_r <= LAST_SECOND);
    stat.enc_year_done = (cy_r == y_r);
    stat.enc_mon_done  = (cm_r == mo_r);
    stat.dec_year_done = (cy_r == LAST_YEAR) || (days_r < {7'b0, ylen});
    stat.dec_mon_done  = (cm_r == 4'd12) || (days_r < {11'b0, mlen});
    stat.out_free      = !out_valid_r || out_ready;
  end

  always_comb begin
    dec_nxt       = dec_r;
    ok_nxt        = ok_r;
    y_nxt         = y_r;
    mo_nxt        = mo_r;
    d_nxt         = d_r;
    h_nxt         = h_r;
    mi_nxt        = mi_r;
    s_nxt         = s_r;
    secs_nxt      = secs_r;
    cy_nxt        = cy_r;
    cm_nxt        = cm_r;
    days_nxt      = days_r;
    doy_nxt       = doy_r;
    wd_nxt        = wd_r;
    part_nxt      = part_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (cmd.op)
      OP_LOAD: begin
        dec_nxt  = in_data.command;
        ok_nxt   = 1'b1;
        y_nxt    = in_data.in_year;
        mo_nxt   = in_data.in_month;
        d_nxt    = in_data.in_day;
        h_nxt    = in_data.in_hour;
        mi_nxt   = in_data.in_minute;
        s_nxt    = in_data.in_second;
        secs_nxt = in_data.in_epoch_seconds;
        cy_nxt   = EPOCH_YEAR;
        cm_nxt   = 4'd1;
        days_nxt = '0;
        doy_nxt  = '0;
        wd_nxt   = WD_EPOCH;
      end
      OP_BAD: begin
        ok_nxt = 1'b0;
      end
      OP_EYEAR: begin
        days_nxt = days_r + {7'b0, ylen};
        wd_nxt   = cec_wd_add(wd_r, 3'd1 + {2'b0, cy_leap});
        cy_nxt   = cy_r + 12'd1;
      end
      OP_EMON: begin
        days_nxt = days_r + {11'b0, mlen};
        doy_nxt  = doy_r + {4'b0, mlen};
        wd_nxt   = cec_wd_add(wd_r, cec_mod7(mlen));
        cm_nxt   = cm_r + 4'd1;
      end
      OP_EDAY: begin
        days_nxt = days_r + {11'b0, d_m1};
        doy_nxt  = doy_r + {4'b0, d_r};
        wd_nxt   = cec_wd_add(wd_r, cec_mod7(d_m1));
      end
      OP_EMUL: begin
        secs_nxt = day_secs[31:0];
      end
      OP_EADD: begin
        secs_nxt = secs_r + {15'b0, hour_secs} + {20'b0, min_secs} + {26'b0, s_r};
      end
      OP_DLOAD: begin
        days_nxt = day_prod[50:35];
      end
      OP_DREM: begin
        part_nxt = secs_r[16:0] - day_secs[16:0];
      end
      OP_HLOAD: begin
        h_nxt = hour_prod[25:21];
      end
      OP_HREM: begin
        part_nxt = part_r - hour_secs;
      end
      OP_MLOAD: begin
        mi_nxt = min_prod[19:14];
      end
      OP_SLOAD: begin
        s_nxt = part_r[5:0] - min_secs[5:0];
      end
      OP_DYEAR: begin
        days_nxt = days_r - {7'b0, ylen};
        wd_nxt   = cec_wd_add(wd_r, 3'd1 + {2'b0, cy_leap});
        cy_nxt   = cy_r + 12'd1;
      end
      OP_DOY: begin
        doy_nxt = days_r[8:0] + 9'd1;
      end
      OP_DMON: begin
        days_nxt = days_r - {11'b0, mlen};
        wd_nxt   = cec_wd_add(wd_r, cec_mod7(mlen));
        cm_nxt   = cm_r + 4'd1;
      end
      OP_DDAY: begin
        d_nxt  = days_r[4:0] + 5'd1;
        wd_nxt = cec_wd_add(wd_r, cec_mod7(days_r[4:0]));
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        if (ok_r) begin
          out_nxt.ok                   = 1'b1;
          out_nxt.out_epoch_seconds    = secs_r;
          out_nxt.out_year             = cy_r;
          out_nxt.out_month            = cm_r;
          out_nxt.out_day              = d_r;
          out_nxt.out_hour             = h_r;
          out_nxt.out_minute           = mi_r;
          out_nxt.out_second           = s_r;
          out_nxt.day_of_year          = doy_r;
          out_nxt.weekday_monday_based = wd_r;
          out_nxt.weekday_sunday_based = cec_wd_add(wd_r, 3'd1);
        end else begin
          out_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cy_r        <= EPOCH_YEAR;
      cm_r        <= 4'd1;
      wd_r        <= WD_EPOCH;
    end else begin
      out_valid_r <= out_valid_nxt;
      cy_r        <= cy_nxt;
      cm_r        <= cm_nxt;
      wd_r        <= wd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dec_r  <= dec_nxt;
    ok_r   <= ok_nxt;
    y_r    <= y_nxt;
    mo_r   <= mo_nxt;
    d_r    <= d_nxt;
    h_r    <= h_nxt;
    mi_r   <= mi_nxt;
    s_r    <= s_nxt;
    secs_r <= secs_nxt;
    days_r <= days_nxt;
    doy_r  <= doy_nxt;
    part_r <= part_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register written while a transaction is still pending");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cy_r >= EPOCH_YEAR) && (cy_r <= LAST_YEAR))
    else $error("year counter left the supported range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cm_r >= 4'd1) && (cm_r <= 4'd12))
    else $error("month counter left 1 to 12");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    wd_r <= 3'd6)
    else $error("weekday accumulator out of range");

endmodule

`default_nettype wire
